// File: src/shunting_yard_infix_to_rpn_top_defines.svh
// Assertion macros for the infix-to-RPN converter.
// Included by the top level only; no other dependencies.
`ifndef SHUNTING_YARD_INFIX_TO_RPN_TOP_DEFINES_SVH
`define SHUNTING_YARD_INFIX_TO_RPN_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define SYP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define SYP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/syp_pkg.sv
// Shared types and codes for the infix-to-RPN converter.
// No dependencies; imported by every module of the block.
package syp_pkg;

    // Input token kinds
    localparam logic [2:0] IN_NUM   = 3'd0;
    localparam logic [2:0] IN_FUNC  = 3'd1;
    localparam logic [2:0] IN_OPER  = 3'd2;
    localparam logic [2:0] IN_LBRK  = 3'd3;
    localparam logic [2:0] IN_RBRK  = 3'd4;
    localparam logic [2:0] IN_COMMA = 3'd5;
    localparam logic [2:0] IN_END   = 3'd6;

    // Stack entry kinds
    localparam logic [1:0] ENT_OPER = 2'd0;
    localparam logic [1:0] ENT_FUNC = 2'd1;
    localparam logic [1:0] ENT_LBRK = 2'd2;

    // Result kinds
    localparam logic [1:0] OUT_NUM  = 2'd0;
    localparam logic [1:0] OUT_OPER = 2'd1;
    localparam logic [1:0] OUT_FUNC = 2'd2;
    localparam logic [1:0] OUT_MARK = 2'd3;

    // Status codes on the final marker
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // Command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    // Commands handed from the front to the back
    typedef enum logic [2:0] {
        CMD_NUM,
        CMD_PUSH,
        CMD_OPER,
        CMD_COMMA,
        CMD_RBRK,
        CMD_END
    } cmd_kind_t;

    // Stack entry attributes: bit 6 right assoc, bits 5:2 precedence, 1:0 kind
    typedef struct packed {
        logic       rassoc;
        logic [3:0] prec;
        logic [1:0] ent;
    } attr_t;

    typedef struct packed {
        attr_t       attr;
        logic [63:0] payload;
    } entry_t;

    typedef struct packed {
        cmd_kind_t   kind;
        attr_t       attr;
        logic [63:0] value;
    } cmd_t;

endpackage

// File: src/syp_front.sv
// Front end: accepts infix tokens, classifies them into commands.
// Depends on syp_pkg; feeds the command queue.
module syp_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [2:0]     in_kind,
    input  logic [63:0]    in_value,
    input  logic [3:0]     in_prec,
    input  logic           in_rassoc,
    input  logic           q_full,
    output logic           q_push,
    output syp_pkg::cmd_t  q_data
);
    import syp_pkg::*;

    logic  stage_valid_reg, stage_valid_next;
    cmd_t  stage_reg, stage_next;
    cmd_t  dec_cmd;
    logic  dec_keep;
    logic  accept;

    // Token decoder
    always_comb
    begin
        dec_keep            = 1'b1;
        dec_cmd.kind        = CMD_NUM;
        dec_cmd.value       = in_value;
        dec_cmd.attr.rassoc = 1'b0;
        dec_cmd.attr.prec   = 4'd0;
        dec_cmd.attr.ent    = ENT_OPER;
        unique case (in_kind)
            IN_NUM:   dec_cmd.kind = CMD_NUM;
            IN_FUNC:
            begin
                dec_cmd.kind     = CMD_PUSH;
                dec_cmd.attr.ent = ENT_FUNC;
            end
            IN_LBRK:
            begin
                dec_cmd.kind     = CMD_PUSH;
                dec_cmd.attr.ent = ENT_LBRK;
            end
            IN_OPER:
            begin
                dec_cmd.kind        = CMD_OPER;
                dec_cmd.attr.prec   = in_prec;
                dec_cmd.attr.rassoc = in_rassoc;
            end
            IN_RBRK:  dec_cmd.kind = CMD_RBRK;
            IN_COMMA: dec_cmd.kind = CMD_COMMA;
            IN_END:   dec_cmd.kind = CMD_END;
            default:  dec_keep = 1'b0;  // unused kind: dropped
        endcase
    end

    // One holding stage in front of the queue
    assign q_push   = stage_valid_reg && !q_full;
    assign q_data   = stage_reg;
    assign in_ready = !stage_valid_reg || !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg && !q_push;
        stage_next       = stage_reg;
        if (accept && dec_keep)
        begin
            stage_valid_next = 1'b1;
            stage_next       = dec_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

endmodule

// File: src/syp_fifo.sv
// Short command queue between the front and the back.
// Depends on syp_pkg for the command type and depth.
module syp_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  syp_pkg::cmd_t  wr_data,
    output logic           full,
    input  logic           pop,
    output syp_pkg::cmd_t  rd_data,
    output logic           empty
);
    import syp_pkg::*;

    cmd_t           buf_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]   fill_reg, fill_next;

    assign full    = (fill_reg == (QAW+1)'(QDEPTH));
    assign empty   = (fill_reg == '0);
    assign rd_data = buf_reg[rd_ptr_reg];

    // Pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QAW'(push);
        rd_ptr_next = rd_ptr_reg + QAW'(pop);
        fill_next   = fill_reg + (QAW+1)'(push) - (QAW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// File: src/syp_back.sv
// Back end: operator stack, pop/push sequencer and result register.
// Depends on syp_pkg; takes commands from the queue.
module syp_back #(
    parameter int STACK_DEPTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  syp_pkg::cmd_t  q_data,
    output logic           q_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [1:0]     m_kind,
    output logic [63:0]    m_value,
    output logic [1:0]     m_status,
    output logic           m_last
);
    import syp_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_RFUNC,
        S_FILL
    } state_t;

    state_t       state_reg, state_next;
    state_t       ret_reg, ret_next, ret_sel;
    logic [CW-1:0] count_reg, count_next;
    logic [1:0]   err_reg, err_next;
    entry_t       top_reg, top_next;
    cmd_t         cmd_reg, cmd_next;

    logic         out_valid_reg, out_valid_next;
    logic [1:0]   out_kind_reg, out_kind_next;
    logic [63:0]  out_value_reg, out_value_next;
    logic [1:0]   out_status_reg, out_status_next;
    logic         out_last_reg, out_last_next;

    // Stack body: entries below the cached top
    entry_t       mem [STACK_DEPTH];
    entry_t       rd_data_reg;
    logic         mem_we;
    logic [CW-1:0] cnt_m1, cnt_m2;

    logic         out_free, have_top, pops_op;
    logic         do_pop, pop_emit, do_push;
    logic         emit_num, emit_mark;

    assign out_free = !out_valid_reg || m_ready;
    assign have_top = (count_reg != '0);
    assign cnt_m1   = count_reg - CW'(1);
    assign cnt_m2   = count_reg - CW'(2);
    assign pops_op  = cmd_reg.attr.rassoc ? (top_reg.attr.prec > cmd_reg.attr.prec)
                                          : (top_reg.attr.prec >= cmd_reg.attr.prec);

    assign m_valid  = out_valid_reg;
    assign m_kind   = out_kind_reg;
    assign m_value  = out_value_reg;
    assign m_status = out_status_reg;
    assign m_last   = out_last_reg;

    // Sequencer: one stack action per cycle at most; emitting pops wait while the result register is held
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        ret_sel    = S_RUN;
        cmd_next   = cmd_reg;
        q_pop      = 1'b0;
        do_pop     = 1'b0;
        pop_emit   = 1'b0;
        do_push    = 1'b0;
        emit_num   = 1'b0;
        emit_mark  = 1'b0;
        err_next   = err_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_data;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                case (cmd_reg.kind)
                    CMD_NUM:
                    begin
                        if (out_free)
                        begin
                            emit_num   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    CMD_PUSH:
                    begin
                        do_push    = 1'b1;
                        state_next = S_IDLE;
                    end
                    CMD_OPER:
                    begin
                        if (have_top && top_reg.attr.ent == ENT_OPER && pops_op)
                        begin
                            do_pop   = out_free;
                            pop_emit = out_free;
                        end
                        else
                        begin
                            do_push    = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    CMD_COMMA:
                    begin
                        if (have_top && top_reg.attr.ent != ENT_LBRK)
                        begin
                            do_pop   = out_free;
                            pop_emit = out_free;
                        end
                        else
                        begin
                            if (!have_top && err_reg == ST_OK)
                                err_next = ST_MISMATCH;
                            state_next = S_IDLE;
                        end
                    end
                    CMD_RBRK:
                    begin
                        if (have_top && top_reg.attr.ent != ENT_LBRK)
                        begin
                            do_pop   = out_free;
                            pop_emit = out_free;
                        end
                        else if (!have_top)
                        begin
                            if (err_reg == ST_OK)
                                err_next = ST_MISMATCH;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            // drop the bracket, then look for a function
                            do_pop  = 1'b1;
                            ret_sel = S_RFUNC;
                        end
                    end
                    CMD_END:
                    begin
                        if (have_top)
                        begin
                            if (top_reg.attr.ent == ENT_LBRK)
                            begin
                                if (err_reg == ST_OK)
                                    err_next = ST_MISMATCH;
                                do_pop = 1'b1;
                            end
                            else
                            begin
                                do_pop   = out_free;
                                pop_emit = out_free;
                            end
                        end
                        else if (out_free)
                        begin
                            emit_mark  = 1'b1;
                            err_next   = ST_OK;
                            state_next = S_IDLE;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_RFUNC:
            begin
                if (have_top && top_reg.attr.ent == ENT_FUNC)
                begin
                    do_pop   = out_free;
                    pop_emit = out_free;
                    ret_sel  = S_IDLE;
                end
                else
                    state_next = S_IDLE;
            end
            S_FILL:
            begin
                state_next = ret_reg;
            end
            default: state_next = S_IDLE;
        endcase

        // Pop: the entry below the top is read back in the following cycle (S_FILL)
        if (do_pop)
        begin
            if (count_reg > CW'(1))
            begin
                state_next = S_FILL;
                ret_next   = ret_sel;
            end
            else
                state_next = ret_sel;
        end

        // Push onto a full stack is dropped
        if (do_push && count_reg >= CW'(STACK_DEPTH) && err_reg == ST_OK)
            err_next = ST_OVERFLOW;
    end

    // Stack pointer, cached top and memory write
    always_comb
    begin
        count_next = count_reg;
        top_next   = top_reg;
        mem_we     = 1'b0;
        if (state_reg == S_FILL)
            top_next = rd_data_reg;
        if (do_pop)
            count_next = cnt_m1;
        if (do_push && count_reg < CW'(STACK_DEPTH))
        begin
            mem_we       = have_top;
            top_next     = {cmd_reg.attr, cmd_reg.value};
            count_next   = count_reg + CW'(1);
        end
        if (emit_mark)
            count_next = '0;
    end

    // Result register
    always_comb
    begin
        out_valid_next  = out_valid_reg && !m_ready;
        out_kind_next   = out_kind_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        if (emit_num)
        begin
            out_valid_next  = 1'b1;
            out_kind_next   = OUT_NUM;
            out_value_next  = cmd_reg.value;
            out_status_next = ST_OK;
            out_last_next   = 1'b0;
        end
        else if (pop_emit)
        begin
            out_valid_next  = 1'b1;
            out_kind_next   = (top_reg.attr.ent == ENT_FUNC) ? OUT_FUNC : OUT_OPER;
            out_value_next  = top_reg.payload;
            out_status_next = ST_OK;
            out_last_next   = 1'b0;
        end
        else if (emit_mark)
        begin
            out_valid_next  = 1'b1;
            out_kind_next   = OUT_MARK;
            out_value_next  = '0;
            out_status_next = err_reg;
            out_last_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            count_reg      <= '0;
            err_reg        <= ST_OK;
            out_valid_reg  <= 1'b0;
            out_kind_reg   <= OUT_NUM;
            out_value_reg  <= '0;
            out_status_reg <= ST_OK;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            count_reg      <= count_next;
            err_reg        <= err_next;
            out_valid_reg  <= out_valid_next;
            out_kind_reg   <= out_kind_next;
            out_value_reg  <= out_value_next;
            out_status_reg <= out_status_next;
            out_last_reg   <= out_last_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        top_reg <= top_next;
    end

    // Stack memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[cnt_m1[AW-1:0]] <= top_reg;
        rd_data_reg <= mem[cnt_m2[AW-1:0]];
    end

endmodule

// File: src/shunting_yard_infix_to_rpn_top.sv
// Infix-to-RPN converter top level: front decoder, command queue, stack engine.
// A number passes the front holding stage, command queue, command register and
// result register. Each token taken from the queue passes S_IDLE and S_RUN; a
// stack pop adds an S_RUN step, and S_FILL refills the cached top when entries
// remain below it; a right bracket adds S_RFUNC to look for its function.
// Reset: rst_n asynchronous, clears stack count, error, queue and handshakes;
// stack memory contents are not cleared.
module shunting_yard_infix_to_rpn_top #(
    parameter int STACK_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // in_value[63:0], precedence[67:64],
                                        // right_assoc[68], zero pad[71:69]
    input  logic [2:0]  s_axis_tuser,   // in_kind[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // out_value[63:0], status[65:64],
                                        // zero pad[71:66]
    output logic [1:0]  m_axis_tuser,   // out_kind[1:0]
    output logic        m_axis_tlast
);
    import syp_pkg::*;

    logic        q_push, q_full, q_pop, q_empty;
    cmd_t        q_wr_data, q_rd_data;
    logic [63:0] out_value;
    logic [1:0]  out_status;

    // Front: token classification
    syp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_kind   (s_axis_tuser),
        .in_value  (s_axis_tdata[63:0]),
        .in_prec   (s_axis_tdata[67:64]),
        .in_rassoc (s_axis_tdata[68]),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_wr_data)
    );

    // Command queue
    syp_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_data),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    // Back: stack engine and result register
    syp_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_data   (q_rd_data),
        .q_pop    (q_pop),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_kind   (m_axis_tuser),
        .m_value  (out_value),
        .m_status (out_status),
        .m_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, out_status, out_value};

    // Checks
`include "shunting_yard_infix_to_rpn_top_defines.svh"

    `SYP_ASSERT_IMP(a_q_no_overrun, clk, rst_n, q_full, !q_push, "command queue overrun")
    `SYP_ASSERT_IMP(a_q_no_underrun, clk, rst_n, q_empty, !q_pop, "command queue underrun")
    `SYP_ASSERT_NXT(a_q_fills, clk, rst_n, q_push && q_empty, !q_empty, "queue lost a command")
    `SYP_ASSERT_IMP(a_mark_fields, clk, rst_n, m_axis_tvalid && m_axis_tlast,
        m_axis_tuser == OUT_MARK && out_value == 64'd0, "final marker malformed")

endmodule

// File: tb/sv/tb_syp_checker.sv
// Result checker for the infix-to-RPN converter: tracks its own operator stack and
// compares every output request with the token order it predicts.
// Depends on syp_pkg for token, entry, result and status codes.
`timescale 1ns / 100ps

module tb_syp_checker #(
    parameter int STACK_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // in_value[63:0], precedence[67:64],
                                        // right_assoc[68], zero pad[71:69]
    input  logic [2:0]  s_axis_tuser,   // in_kind[2:0]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [71:0] m_axis_tdata,   // out_value[63:0], status[65:64],
                                        // zero pad[71:66]
    input  logic [1:0]  m_axis_tuser,   // out_kind[1:0]
    input  logic        m_axis_tlast,
    output int          fail_count,
    output int          pending
);
    import syp_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] value;
        logic [1:0]  status;
        logic        last;
    } rpn_token_t;

    // Predicted operator stack and pending error
    logic [63:0] op_payload [STACK_DEPTH];
    attr_t       op_attr    [STACK_DEPTH];
    int          op_depth;
    logic [1:0]  err_code;

    rpn_token_t  rpn_expected [$];

    // Keep the first error of an expression
    function automatic void note_error(input logic [1:0] code);
        if (err_code == ST_OK)
            err_code = code;
    endfunction

    function automatic void expect_token(input logic [1:0] kind, input logic [63:0] value,
                                         input logic [1:0] status, input logic last);
        rpn_token_t t;
        t.kind   = kind;
        t.value  = value;
        t.status = status;
        t.last   = last;
        rpn_expected.push_back(t);
    endfunction

    // Pop the top entry; brackets vanish silently
    function automatic void pop_top();
        attr_t a;
        op_depth = op_depth - 1;
        a = op_attr[op_depth];
        if (a.ent == ENT_OPER)
            expect_token(OUT_OPER, op_payload[op_depth], ST_OK, 1'b0);
        else if (a.ent == ENT_FUNC)
            expect_token(OUT_FUNC, op_payload[op_depth], ST_OK, 1'b0);
    endfunction

    // A full stack drops the entry and flags overflow
    function automatic void push_entry(input logic [63:0] value, input attr_t a);
        if (op_depth >= STACK_DEPTH)
        begin
            note_error(ST_OVERFLOW);
        end
        else
        begin
            op_payload[op_depth] = value;
            op_attr[op_depth]    = a;
            op_depth             = op_depth + 1;
        end
    endfunction

    function automatic logic [1:0] top_ent();
        return op_attr[op_depth - 1].ent;
    endfunction

    // One infix token in, its ready postfix tokens onto rpn_expected
    function automatic void convert_token(input logic [2:0] kind, input logic [63:0] value,
                                          input logic [3:0] prec, input logic rassoc);
        attr_t      a;
        logic [3:0] top_prec;
        bit         settled;
        a.rassoc = 1'b0;
        a.prec   = 4'd0;
        a.ent    = ENT_OPER;
        settled  = 1'b0;
        case (kind)
            IN_NUM:
                expect_token(OUT_NUM, value, ST_OK, 1'b0);
            IN_FUNC:
            begin
                a.ent = ENT_FUNC;
                push_entry(value, a);
            end
            IN_LBRK:
            begin
                a.ent = ENT_LBRK;
                push_entry(value, a);
            end
            IN_OPER:
            begin
                // right associative pops only strictly tighter operators
                while (!settled && op_depth > 0 && top_ent() == ENT_OPER)
                begin
                    top_prec = op_attr[op_depth - 1].prec;
                    if (rassoc ? (top_prec > prec) : (top_prec >= prec))
                        pop_top();
                    else
                        settled = 1'b1;
                end
                a.rassoc = rassoc;
                a.prec   = prec;
                push_entry(value, a);
            end
            IN_COMMA:
            begin
                while (op_depth > 0 && top_ent() != ENT_LBRK)
                    pop_top();
                if (op_depth == 0)
                    note_error(ST_MISMATCH);
            end
            IN_RBRK:
            begin
                while (op_depth > 0 && top_ent() != ENT_LBRK)
                    pop_top();
                if (op_depth == 0)
                begin
                    note_error(ST_MISMATCH);
                end
                else
                begin
                    op_depth = op_depth - 1;
                    if (op_depth > 0 && top_ent() == ENT_FUNC)
                        pop_top();
                end
            end
            IN_END:
            begin
                // unclosed brackets are dropped but flagged
                while (op_depth > 0)
                begin
                    if (top_ent() == ENT_LBRK)
                        note_error(ST_MISMATCH);
                    pop_top();
                end
                expect_token(OUT_MARK, 64'd0, err_code, 1'b1);
                err_code = ST_OK;
            end
            default:
                ;
        endcase
    endfunction

    // Watch both channels; outputs are checked before the new request is predicted
    always @(posedge clk or negedge rst_n)
    begin
        rpn_token_t got;
        rpn_token_t want;
        if (!rst_n)
        begin
            op_depth = 0;
            err_code = ST_OK;
            rpn_expected.delete();
            fail_count = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.kind   = m_axis_tuser;
                got.value  = m_axis_tdata[63:0];
                got.status = m_axis_tdata[65:64];
                got.last   = m_axis_tlast;
                if (rpn_expected.size() == 0)
                begin
                    fail_count = fail_count + 1;
                    $display("%0t: expected no result, got kind %0d value %h status %0d last %0d",
                             $time, got.kind, got.value, got.status, got.last);
                end
                else
                begin
                    want = rpn_expected.pop_front();
                    if (got !== want)
                    begin
                        fail_count = fail_count + 1;
                        $display("%0t: expected kind %0d value %h status %0d last %0d,",
                                 $time, want.kind, want.value, want.status, want.last);
                        $display("%0t:      got kind %0d value %h status %0d last %0d",
                                 $time, got.kind, got.value, got.status, got.last);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                convert_token(s_axis_tuser, s_axis_tdata[63:0], s_axis_tdata[67:64],
                              s_axis_tdata[68]);
        end
        pending = rpn_expected.size();
    end

endmodule

// File: tb/sv/tb_shunting_yard_infix_to_rpn_top.sv
// Testbench top for the infix-to-RPN converter: clock, reset, token stimulus and verdict.
// Depends on syp_pkg, shunting_yard_infix_to_rpn_top and tb_syp_checker.
`timescale 1ns / 100ps

module tb_shunting_yard_infix_to_rpn_top;
    import syp_pkg::*;

    localparam logic [2:0] IN_UNUSED    = 3'd7;
    localparam int         TOTAL_TOKENS = 200;
    localparam int         HOLD_AFTER   = 60;
    localparam int         HOLD_CYCLES  = 400;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;      // in_value[63:0], precedence[67:64],
                                    // right_assoc[68], zero pad[71:69]
    logic [2:0]  s_axis_tuser;      // in_kind[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;      // out_value[63:0], status[65:64], zero pad[71:66]
    logic [1:0]  m_axis_tuser;      // out_kind[1:0]
    logic        m_axis_tlast;
    int          fail_count;
    int          pending;

    int          tokens_sent;
    bit          tx_eager;

    shunting_yard_infix_to_rpn_top dut (.*);

    tb_syp_checker checker_i (.*);

    // 4 ns clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic logic [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // Offer one request after a random gap; valid stays high across back-to-back requests
    task automatic send_token(input logic [2:0] kind, input logic [63:0] value,
                              input logic [3:0] prec, input logic rassoc);
        int gap;
        if ($urandom_range(0, 15) == 0)
            tx_eager = !tx_eager;
        gap = tx_eager ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, rassoc, prec, value};
        s_axis_tuser  <= kind;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (kind != IN_UNUSED)
            tokens_sent = tokens_sent + 1;
    endtask

    // Random payload; precedence often clustered so that ties occur
    task automatic send_any(input logic [2:0] kind);
        logic [3:0] prec;
        prec = $urandom_range(0, 1) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(6, 8));
        send_token(kind, rand_word(), prec, 1'($urandom_range(0, 1)));
    endtask

    // Well-formed expression with random content, closed and terminated
    task automatic send_expression();
        bit is_call [64];
        int open;
        int len;
        int r;
        bit want_operand;
        want_operand = 1'b1;
        open = 0;
        len = $urandom_range(1, 14);
        repeat (len)
        begin
            r = $urandom_range(0, 9);
            if (want_operand)
            begin
                if (r < 6 || open >= 60)
                begin
                    send_any(IN_NUM);
                    want_operand = 1'b0;
                end
                else if (r < 8)
                begin
                    send_any(IN_LBRK);
                    is_call[open] = 1'b0;
                    open = open + 1;
                end
                else
                begin
                    send_any(IN_FUNC);
                    send_any(IN_LBRK);
                    is_call[open] = 1'b1;
                    open = open + 1;
                end
            end
            else
            begin
                if (r >= 6 && r < 8 && open > 0)
                begin
                    send_any(IN_RBRK);
                    open = open - 1;
                end
                else if (r >= 8 && open > 0 && is_call[open - 1])
                begin
                    send_any(IN_COMMA);
                    want_operand = 1'b1;
                end
                else
                begin
                    send_any(IN_OPER);
                    want_operand = 1'b1;
                end
            end
        end
        if (want_operand)
            send_any(IN_NUM);
        while (open > 0)
        begin
            send_any(IN_RBRK);
            open = open - 1;
        end
        send_any(IN_END);
    endtask

    // Nesting up to or past the stack depth; sometimes a stray bracket first so mismatch wins
    task automatic send_deep();
        int n;
        if ($urandom_range(0, 1))
            send_any(IN_RBRK);
        n = $urandom_range(28, 40);
        repeat (n)
            send_any($urandom_range(0, 1) ? IN_LBRK : IN_FUNC);
        send_any(IN_NUM);
        send_any(IN_OPER);
        send_any(IN_NUM);
        repeat ($urandom_range(0, 6))
            send_any(IN_RBRK);
        send_any(IN_END);
    endtask

    // Arbitrary kinds, including the unused code
    task automatic send_noise();
        repeat ($urandom_range(1, 10))
            send_any(3'($urandom_range(0, 7)));
        send_any(IN_END);
    endtask

    // Receiver: random stalls, one long hold-off to back the block up
    initial
    begin : result_sink
        int gap;
        int taken;
        bit eager;
        taken = 0;
        eager = 1'b0;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                eager = !eager;
            if (taken == HOLD_AFTER)
                gap = HOLD_CYCLES;
            else
                gap = eager ? 0 : $urandom_range(0, 17);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            taken = taken + 1;
        end
    end

    // Stimulus and verdict
    initial
    begin : token_source
        int iter;
        int r;
        tokens_sent = 0;
        tx_eager = 1'b0;
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= IN_NUM;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extreme payload and precedence, right-assoc chain, left-assoc ties
        send_token(IN_NUM, '1, 4'd0, 1'b0);
        send_token(IN_OPER, '1, 4'd15, 1'b1);
        send_token(IN_NUM, '0, 4'd15, 1'b1);
        send_token(IN_OPER, 64'h2, 4'd15, 1'b1);
        send_token(IN_NUM, rand_word(), 4'd0, 1'b0);
        send_token(IN_OPER, 64'h3, 4'd0, 1'b0);
        send_token(IN_NUM, rand_word(), 4'd0, 1'b0);
        send_token(IN_OPER, 64'h4, 4'd0, 1'b0);
        send_token(IN_NUM, rand_word(), 4'd0, 1'b0);
        send_token(IN_END, '0, 4'd0, 1'b0);
        // Function call with two arguments
        send_token(IN_FUNC, 64'hF00D, 4'd0, 1'b0);
        send_token(IN_LBRK, 64'h0, 4'd0, 1'b0);
        send_token(IN_NUM, rand_word(), 4'd0, 1'b0);
        send_token(IN_COMMA, 64'h0, 4'd0, 1'b0);
        send_token(IN_NUM, rand_word(), 4'd0, 1'b0);
        send_token(IN_RBRK, 64'h0, 4'd0, 1'b0);
        send_token(IN_END, '1, 4'd15, 1'b1);
        // Stray comma and right bracket, unclosed bracket, unused kind
        send_token(IN_NUM, rand_word(), 4'd0, 1'b0);
        send_token(IN_OPER, 64'h5, 4'd7, 1'b0);
        send_token(IN_COMMA, 64'h0, 4'd0, 1'b0);
        send_token(IN_OPER, 64'h6, 4'd3, 1'b1);
        send_token(IN_RBRK, 64'h0, 4'd0, 1'b0);
        send_token(IN_LBRK, 64'h0, 4'd0, 1'b0);
        send_token(IN_UNUSED, '1, 4'd15, 1'b1);
        send_token(IN_END, 64'h0, 4'd0, 1'b0);

        // Random part: mostly well-formed expressions
        iter = 0;
        while (tokens_sent < TOTAL_TOKENS)
        begin
            r = $urandom_range(0, 11);
            if (iter == 0 || r == 0)
                send_deep();
            else if (r < 4)
                send_noise();
            else
                send_expression();
            iter = iter + 1;
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then let any stray result show up
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/syp_pkg.sv
src/syp_front.sv
src/syp_fifo.sv
src/syp_back.sv
src/shunting_yard_infix_to_rpn_top.sv
tb/sv/tb_syp_checker.sv
tb/sv/tb_shunting_yard_infix_to_rpn_top.sv
